// ----- rtl/sits_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the two-axis saved-index table search.
// This package has no dependencies. Every other file in rtl but sits_ram imports it.
package sits_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int VALUE_W     = 32;
	localparam int COUNT_W     = 9;
	localparam int INDEX_W     = COUNT_W + 1;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;
	localparam int OP_W        = 2;
	localparam int S_DATA_W    = 104;
	localparam int M_DATA_W    = 24;

	localparam logic [OP_W-1:0] OP_WR_X = 2'd0;
	localparam logic [OP_W-1:0] OP_WR_Y = 2'd1;
	localparam logic [OP_W-1:0] OP_FIND = 2'd2;

	localparam logic REG_X_COUNT = 1'b0;
	localparam logic REG_Y_COUNT = 1'b1;

	typedef struct packed {
		logic               done;
		logic [INDEX_W-1:0] index;
		logic               oor;
	} sits_res_t;

endpackage

// ----- rtl/sits_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; used for both breakpoint tables.
module sits_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/sits_lane.sv -----
`timescale 1ns / 1ps
// One search lane: a breakpoint table, the saved index and the walk sequencer.
// Depends on sits_pkg and sits_ram.
module sits_lane (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [sits_pkg::VALUE_W-1:0]    key,
	input  logic [sits_pkg::COUNT_W-1:0]    count,
	input  logic                            wr_en,
	input  logic [sits_pkg::ADDR_W-1:0]     wr_addr,
	input  logic [sits_pkg::VALUE_W-1:0]    wr_data,
	input  logic                            ack,
	output sits_pkg::sits_res_t             res
);
	import sits_pkg::*;

	typedef enum logic [1:0] {L_IDLE, L_WALK, L_DONE} lane_state_t;

	lane_state_t        state_q;
	logic [INDEX_W-1:0] idx_q;
	logic [INDEX_W-1:0] saved_q;
	logic [COUNT_W-1:0] n_q;
	logic [VALUE_W-1:0] key_q;
	logic               first_q;
	logic               down_q;
	logic [INDEX_W-1:0] res_index_q;
	logic               res_oor_q;

	logic [VALUE_W-1:0] rd_data;
	logic [ADDR_W-1:0]  rd_addr;
	logic [COUNT_W-1:0] n_lim;
	logic [INDEX_W-1:0] start_last;
	logic [INDEX_W-1:0] i0;
	logic               lt;
	logic               down;
	logic [INDEX_W-1:0] n_ext;
	logic [INDEX_W-1:0] idx_dn;
	logic [INDEX_W-1:0] idx_up;
	logic [INDEX_W-1:0] step_idx;
	logic               fin;
	logic [INDEX_W-1:0] fin_idx;
	logic               fin_oor;

	sits_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_comb begin
		n_lim = (count > COUNT_W'(TABLE_DEPTH)) ? COUNT_W'(TABLE_DEPTH) : count;
		start_last = {1'b0, n_lim} - INDEX_W'(2);
		if (saved_q[INDEX_W-1]) begin
			i0 = '0;
		end else if (saved_q > start_last) begin
			i0 = start_last;
		end else begin
			i0 = saved_q;
		end
	end

	always_comb begin
		lt       = $signed(key_q) < $signed(rd_data);
		down     = first_q ? lt : down_q;
		n_ext    = {1'b0, n_q};
		idx_dn   = idx_q - INDEX_W'(1);
		idx_up   = idx_q + INDEX_W'(1);
		step_idx = idx_q;
		fin      = 1'b0;
		fin_idx  = idx_q;
		fin_oor  = 1'b0;
		if (down) begin
			if (lt) begin
				if (idx_q == '0) begin
					fin     = 1'b1;
					fin_idx = '1;
					fin_oor = 1'b1;
				end else begin
					step_idx = idx_dn;
				end
			end else begin
				fin = 1'b1;
			end
		end else begin
			if (!lt) begin
				if (idx_up == n_ext) begin
					fin = 1'b1;
					if (key_q == rd_data) begin
						fin_idx = n_ext - INDEX_W'(2);
					end else begin
						fin_idx = n_ext;
						fin_oor = 1'b1;
					end
				end else begin
					step_idx = idx_up;
				end
			end else begin
				fin     = 1'b1;
				fin_idx = idx_dn;
			end
		end
	end

	assign rd_addr = (state_q == L_IDLE) ? i0[ADDR_W-1:0] : step_idx[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			saved_q <= '0;
			first_q <= 1'b0;
			down_q  <= 1'b0;
		end else begin
			unique case (state_q)
				L_IDLE: begin
					if (start) begin
						if (n_lim <= COUNT_W'(1)) begin
							res_index_q <= '0;
							res_oor_q   <= 1'b0;
							saved_q     <= '0;
							state_q     <= L_DONE;
						end else begin
							idx_q   <= i0;
							n_q     <= n_lim;
							key_q   <= key;
							first_q <= 1'b1;
							state_q <= L_WALK;
						end
					end
				end
				L_WALK: begin
					first_q <= 1'b0;
					down_q  <= down;
					idx_q   <= step_idx;
					if (fin) begin
						res_index_q <= fin_idx;
						res_oor_q   <= fin_oor;
						saved_q     <= fin_idx;
						state_q     <= L_DONE;
					end
				end
				L_DONE: begin
					if (ack) begin
						state_q <= L_IDLE;
					end
				end
				default: begin
					state_q <= L_IDLE;
				end
			endcase
		end
	end

	assign res.done  = (state_q == L_DONE);
	assign res.index = res_index_q;
	assign res.oor   = res_oor_q;

endmodule

// ----- rtl/sits_merge.sv -----
`timescale 1ns / 1ps
// Merging stage: joins the two lane results into one output beat register.
// Depends on sits_pkg.
module sits_merge (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sits_pkg::sits_res_t           x_res,
	input  sits_pkg::sits_res_t           y_res,
	output logic                          ack,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [sits_pkg::M_DATA_W-1:0] m_tdata
);
	import sits_pkg::*;

	logic                m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;

	assign ack = x_res.done && y_res.done && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ack) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ack) begin
			m_tdata_q <= {3'b000, x_res.oor || y_res.oor, y_res.index, x_res.index};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ----- rtl/saved_index_table_search_2d.sv -----
`timescale 1ns / 1ps
// Top level of the two-axis breakpoint search with saved start indices.
// A find beat runs both axis walks side by side; each walk reads one breakpoint per cycle.
// The result beat waits for the slower axis, and no new beat is taken until both walks
// are done and the result is loaded into the output register.
// Reset clears the counts, the saved indices and all handshake state; tables are not cleared.
module saved_index_table_search_2d (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sits_pkg::PADDR_W-1:0]  paddr,
	input  logic [sits_pkg::PDATA_W-1:0]  pwdata,
	output logic [sits_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// entry_index, entry_value, find_x, find_y
	input  logic [sits_pkg::S_DATA_W-1:0] s_tdata,
	// op
	input  logic [sits_pkg::OP_W-1:0]     s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// x_index, y_index, out_of_range, zero padding
	output logic [sits_pkg::M_DATA_W-1:0] m_tdata
);
	import sits_pkg::*;

	logic [COUNT_W-1:0] x_count_q;
	logic [COUNT_W-1:0] y_count_q;
	logic               busy_q;
	logic               s_acc;
	logic               find_start;
	logic               wr_x;
	logic               wr_y;
	logic               ack;
	sits_res_t          x_res;
	sits_res_t          y_res;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_Y_COUNT) ? PDATA_W'(y_count_q) : PDATA_W'(x_count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_count_q <= '0;
			y_count_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_X_COUNT: x_count_q <= pwdata[COUNT_W-1:0];
				REG_Y_COUNT: y_count_q <= pwdata[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign s_tready   = !busy_q;
	assign s_acc      = s_tvalid && s_tready;
	assign find_start = s_acc && (s_tuser == OP_FIND);
	assign wr_x       = s_acc && (s_tuser == OP_WR_X);
	assign wr_y       = s_acc && (s_tuser == OP_WR_Y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (find_start) begin
			busy_q <= 1'b1;
		end else if (ack) begin
			busy_q <= 1'b0;
		end
	end

	sits_lane u_x_lane (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (find_start),
		.key    (s_tdata[71:40]),
		.count  (x_count_q),
		.wr_en  (wr_x),
		.wr_addr(s_tdata[7:0]),
		.wr_data(s_tdata[39:8]),
		.ack    (ack),
		.res    (x_res)
	);

	sits_lane u_y_lane (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (find_start),
		.key    (s_tdata[103:72]),
		.count  (y_count_q),
		.wr_en  (wr_y),
		.wr_addr(s_tdata[7:0]),
		.wr_data(s_tdata[39:8]),
		.ack    (ack),
		.res    (y_res)
	);

	sits_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.x_res   (x_res),
		.y_res   (y_res),
		.ack     (ack),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule

// ----- rtl/sits_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for saved_index_table_search_2d, attached by the bind below.
// Depends on sits_pkg.
module sits_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          pready,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [sits_pkg::OP_W-1:0]     s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [sits_pkg::M_DATA_W-1:0] m_tdata
);
	import sits_pkg::*;

	// A stalled result beat stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	// A find beat blocks the input side on the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == OP_FIND) |=> !s_tready)
		else $error("input accepted while a find is in flight");

	// The only negative index is minus one.
	a_neg: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[9] || m_tdata[19]) |->
			((m_tdata[9] == 1'b0) || (m_tdata[9:0] == 10'h3FF)) &&
			((m_tdata[19] == 1'b0) || (m_tdata[19:10] == 10'h3FF)))
		else $error("negative index other than minus one");

	// An index below the table raises the out-of-range flag.
	a_oor: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ((m_tdata[9:0] == 10'h3FF) || (m_tdata[19:10] == 10'h3FF)) |-> m_tdata[20])
		else $error("out-of-range flag missing");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready && (!m_tvalid || (m_tdata[23:21] == 3'b000)))
		else $error("wait state or nonzero padding");

endmodule

bind saved_index_table_search_2d sits_checker u_sits_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.pready  (pready),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for saved_index_table_search_2d: directed rows, then random phases.
// Depends on rtl/sits_pkg.sv and rtl/saved_index_table_search_2d.sv.
module tb;
	import sits_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]     op;
		logic [ADDR_W-1:0]   pos;
		logic signed [31:0]  val;
		logic signed [31:0]  fx;
		logic signed [31:0]  fy;
	} item_t;

	typedef struct packed {
		logic signed [9:0] xi;
		logic signed [9:0] yi;
		logic              oor;
	} res_t;

	typedef struct packed {
		bit    is_reg;
		logic  reg_sel;
		item_t it;
		bit    typed;
		res_t  res;
	} row_t;

	typedef enum {FILL_SORTED, FILL_DUPS, FILL_SPAN, FILL_SCRAMBLE} fill_t;
	typedef enum {READY_ALWAYS, READY_COIN, READY_PERIODIC, READY_SPARSE} ready_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [PADDR_W-1:0]   paddr = '0;
	logic [PDATA_W-1:0]   pwdata = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	// entry_index, entry_value, find_x, find_y
	logic [S_DATA_W-1:0]  s_tdata = '0;
	// op
	logic [OP_W-1:0]      s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// x_index, y_index, out_of_range, zero padding
	logic [M_DATA_W-1:0]  m_tdata;

	bit signed [31:0] x_tab [TABLE_DEPTH];
	bit signed [31:0] y_tab [TABLE_DEPTH];
	bit               x_set [TABLE_DEPTH];
	bit               y_set [TABLE_DEPTH];
	int               x_saved = 0;
	int               y_saved = 0;
	int               x_cnt = 0;
	int               y_cnt = 0;

	res_t             expected_locs [$];
	res_t             want;
	int               fail_count = 0;
	int               burst_left = 0;
	int               sent_items = 0;
	int unsigned      stall_cycle = 0;
	ready_mode_t      ready_mode = READY_ALWAYS;

	row_t directed_rows [23] = '{
		'{0, REG_X_COUNT, '{OP_FIND, 8'd0, 32'sd0, 32'sh80000000, 32'sh7FFFFFFF}, 1,
			'{10'sd0, 10'sd0, 1'b0}},
		'{0, REG_X_COUNT, '{OP_FIND, 8'd0, 32'sd0, 32'sh7FFFFFFF, 32'sh80000000}, 1,
			'{10'sd0, 10'sd0, 1'b0}},
		'{0, REG_X_COUNT, '{OP_WR_X, 8'd0, 32'sh80000000, 32'sd0, 32'sd0}, 0, '0},
		'{0, REG_X_COUNT, '{OP_WR_X, 8'd1, 32'sd0, 32'sd0, 32'sd0}, 0, '0},
		'{0, REG_X_COUNT, '{OP_WR_X, 8'd2, 32'sh7FFFFFFF, 32'sd0, 32'sd0}, 0, '0},
		'{0, REG_X_COUNT, '{OP_WR_Y, 8'd0, -32'sd100, 32'sd0, 32'sd0}, 0, '0},
		'{0, REG_X_COUNT, '{OP_WR_Y, 8'd1, 32'sd100, 32'sd0, 32'sd0}, 0, '0},
		'{0, REG_X_COUNT, '{OP_WR_X, 8'd255, 32'sh5A5A5A5A, 32'sd0, 32'sd0}, 0, '0},
		'{0, REG_X_COUNT, '{OP_WR_Y, 8'd255, 32'shA5A5A5A5, 32'sd0, 32'sd0}, 0, '0},
		'{0, REG_X_COUNT, '{OP_UNUSED, 8'd255, -32'sd1, -32'sd1, -32'sd1}, 0, '0},
		'{1, REG_X_COUNT, '{OP_WR_X, 8'd0, 32'sd3, 32'sd0, 32'sd0}, 0, '0},
		'{1, REG_Y_COUNT, '{OP_WR_X, 8'd0, 32'sd2, 32'sd0, 32'sd0}, 0, '0},
		'{0, REG_X_COUNT, '{OP_FIND, 8'd0, 32'sd0, 32'sd0, -32'sd100}, 1,
			'{10'sd1, 10'sd0, 1'b0}},
		'{0, REG_X_COUNT, '{OP_FIND, 8'd0, 32'sd0, 32'sh7FFFFFFF, 32'sd100}, 1,
			'{10'sd1, 10'sd0, 1'b0}},
		'{0, REG_X_COUNT, '{OP_FIND, 8'd0, 32'sd0, 32'sh80000000, -32'sd101}, 1,
			'{10'sd0, -10'sd1, 1'b1}},
		'{0, REG_X_COUNT, '{OP_FIND, 8'd0, 32'sd0, 32'sd1, 32'sd101}, 1,
			'{10'sd1, 10'sd2, 1'b1}},
		'{0, REG_X_COUNT, '{OP_WR_X, 8'd1, 32'sh7FFF0000, 32'sd0, 32'sd0}, 0, '0},
		'{0, REG_X_COUNT, '{OP_FIND, 8'd0, 32'sd0, 32'sh7FFF0001, 32'sd0}, 0, '0},
		'{0, REG_X_COUNT, '{OP_FIND, 8'd0, 32'sd0, 32'sd0, 32'sd0}, 0, '0},
		'{1, REG_X_COUNT, '{OP_WR_X, 8'd0, 32'sd1, 32'sd0, 32'sd0}, 0, '0},
		'{1, REG_Y_COUNT, '{OP_WR_X, 8'd0, 32'sd0, 32'sd0, 32'sd0}, 0, '0},
		'{0, REG_X_COUNT, '{OP_FIND, 8'd0, 32'sd0, -32'sd1, -32'sd1}, 1,
			'{10'sd0, 10'sd0, 1'b0}},
		'{0, REG_X_COUNT, '{OP_FIND, 8'd0, 32'sd0, 32'sd0, 32'sd0}, 1,
			'{10'sd0, 10'sd0, 1'b0}}
	};

	saved_index_table_search_2d dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#30_000_000;
		$display("saved_index_table_search_2d: mismatch");
		$finish;
	end

	function automatic logic signed [31:0] breakpoint_at(input bit on_y, input int i);
		return on_y ? y_tab[i[7:0]] : x_tab[i[7:0]];
	endfunction

	function automatic bit walk_axis(input bit on_y, input logic signed [31:0] v, input int cnt,
			inout int idx);
		int n;
		int i;
		n = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;
		i = idx;
		if (n <= 1) begin
			idx = 0;
			return 1'b0;
		end
		if (i < 0) i = 0;
		if (i > n - 2) i = n - 2;
		if (v < breakpoint_at(on_y, i)) begin
			while (i >= 0 && v < breakpoint_at(on_y, i)) i--;
		end else begin
			while (i < n && v >= breakpoint_at(on_y, i)) i++;
			if (i < n) i--;
			else if (v == breakpoint_at(on_y, n - 1)) i = n - 2;
		end
		idx = i;
		return (i < 0 || i >= n - 1);
	endfunction

	function automatic bit locate(input item_t it, output res_t r);
		bit xo;
		bit yo;
		case (it.op)
			OP_WR_X: begin
				x_tab[it.pos] = it.val;
				x_set[it.pos] = 1'b1;
				return 1'b0;
			end
			OP_WR_Y: begin
				y_tab[it.pos] = it.val;
				y_set[it.pos] = 1'b1;
				return 1'b0;
			end
			OP_FIND: begin
				xo = walk_axis(1'b0, it.fx, x_cnt, x_saved);
				yo = walk_axis(1'b1, it.fy, y_cnt, y_saved);
				r.xi = x_saved[9:0];
				r.yi = y_saved[9:0];
				r.oor = xo | yo;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic signed [31:0] pick_value(input bit on_y, input int m);
		int j;
		int s;
		if (m < 2) return $urandom;
		j = $urandom_range(0, m - 1);
		s = on_y ? y_saved : x_saved;
		if (s < 0) s = 0;
		if (s > m - 1) s = m - 1;
		case ($urandom_range(0, 8))
			0: return breakpoint_at(on_y, j);
			1: return breakpoint_at(on_y, j) + $urandom_range(0, 6) - 3;
			2: return 32'sh80000000;
			3: return 32'sh7FFFFFFF;
			4: return $urandom;
			5: return breakpoint_at(on_y, m - 1) + $urandom_range(0, 1);
			6: return breakpoint_at(on_y, 0) - 1;
			default: return breakpoint_at(on_y, s) + $urandom_range(0, 2) - 1;
		endcase
	endfunction

	function automatic int pick_count();
		case ($urandom_range(0, 31))
			0, 1: return 0;
			2, 3: return 1;
			4, 5: return 2;
			6: return TABLE_DEPTH;
			7: return $urandom_range(TABLE_DEPTH + 1, 511);
			8, 9, 10, 11, 12, 13: return $urandom_range(17, 64);
			default: return $urandom_range(3, 16);
		endcase
	endfunction

	function automatic fill_t pick_fill();
		case ($urandom_range(0, 7))
			0: return FILL_SCRAMBLE;
			1: return FILL_DUPS;
			2: return FILL_SPAN;
			default: return FILL_SORTED;
		endcase
	endfunction

	task automatic quiesce();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (expected_locs.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_count(input logic sel, input logic [31:0] value);
		quiesce();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		if (sel == REG_X_COUNT) x_cnt = value[COUNT_W-1:0];
		else y_cnt = value[COUNT_W-1:0];
	endtask

	task automatic send_item(input item_t it, input bit typed, input res_t typed_res);
		res_t got;
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 12 : 3)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.op;
		s_tdata <= {it.fy, it.fx, it.val, it.pos};
		do @(posedge clk); while (!s_tready);
		burst_left--;
		sent_items++;
		if (locate(it, got)) expected_locs.push_back(typed ? typed_res : got);
	endtask

	task automatic fill_axis(input bit on_y, input int cnt, input fill_t style);
		item_t it;
		logic signed [31:0] v;
		int m;
		bit full;
		m = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;
		full = 1'b1;
		for (int j = 0; j < m; j++) if (!(on_y ? y_set[j] : x_set[j])) full = 1'b0;
		if (m > 64 && full) return;
		v = $signed($urandom_range(0, 32'h7FFFFFFF)) - 32'sh40000000;
		for (int j = 0; j < m; j++) begin
			it.op = on_y ? OP_WR_Y : OP_WR_X;
			it.pos = j[7:0];
			it.fx = $urandom;
			it.fy = $urandom;
			it.val = v;
			v += (style == FILL_DUPS) ? $urandom_range(0, 2) : $urandom_range(1, 1 << 20);
			if (style == FILL_SCRAMBLE) it.val = $urandom;
			if (style == FILL_SPAN && j == 0) it.val = 32'sh80000000;
			if (style == FILL_SPAN && j == m - 1 && m > 1) it.val = 32'sh7FFFFFFF;
			send_item(it, 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		stall_cycle++;
		if (stall_cycle % 97 == 0) ready_mode = ready_mode_t'($urandom_range(0, 3));
		case (ready_mode)
			READY_ALWAYS: m_tready <= 1'b1;
			READY_COIN: m_tready <= $urandom_range(0, 1);
			READY_PERIODIC: m_tready <= (stall_cycle % 5) != 0;
			default: m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_locs.size() == 0) begin
				$error("result beat with nothing expected: m_tdata %h", m_tdata);
				fail_count++;
			end else begin
				want = expected_locs.pop_front();
				if (m_tdata[9:0] !== want.xi) begin
					$error("x_index: expected %0d, got %0d", want.xi, $signed(m_tdata[9:0]));
					fail_count++;
				end
				if (m_tdata[19:10] !== want.yi) begin
					$error("y_index: expected %0d, got %0d", want.yi, $signed(m_tdata[19:10]));
					fail_count++;
				end
				if (m_tdata[20] !== want.oor) begin
					$error("out_of_range: expected %0d, got %0d", want.oor, m_tdata[20]);
					fail_count++;
				end
			end
		end
	end

	initial begin
		item_t it;
		int phase_no;
		int xc;
		int yc;
		int nf;
		logic [31:0] word;
		phase_no = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k]) begin
			if (directed_rows[k].is_reg)
				write_count(directed_rows[k].reg_sel, directed_rows[k].it.val);
			else
				send_item(directed_rows[k].it, directed_rows[k].typed, directed_rows[k].res);
		end

		// The first phase fills both tables completely and sets a count past the depth.
		while (sent_items < 900) begin
			if (phase_no == 0) begin
				xc = TABLE_DEPTH;
				yc = 511;
			end else if (sent_items >= 840) begin
				xc = 511;
				yc = TABLE_DEPTH;
			end else begin
				xc = pick_count();
				yc = pick_count();
			end
			word = $urandom;
			word[COUNT_W-1:0] = xc[COUNT_W-1:0];
			write_count(REG_X_COUNT, word);
			word = $urandom;
			word[COUNT_W-1:0] = yc[COUNT_W-1:0];
			write_count(REG_Y_COUNT, word);
			fill_axis(1'b0, xc, (phase_no == 0) ? FILL_SORTED : pick_fill());
			fill_axis(1'b1, yc, (phase_no == 0) ? FILL_SORTED : pick_fill());
			if (xc > TABLE_DEPTH) xc = TABLE_DEPTH;
			if (yc > TABLE_DEPTH) yc = TABLE_DEPTH;
			nf = $urandom_range(20, 60);
			for (int f = 0; f < nf; f++) begin
				it.fx = $urandom;
				it.fy = $urandom;
				it.val = $urandom;
				it.pos = $urandom;
				case ($urandom_range(0, 19))
					0: it.op = OP_UNUSED;
					1: it.op = OP_WR_X;
					2: it.op = OP_WR_Y;
					default: begin
						it.op = OP_FIND;
						it.fx = pick_value(1'b0, xc);
						it.fy = pick_value(1'b1, yc);
					end
				endcase
				send_item(it, 1'b0, '0);
			end
			phase_no++;
		end

		quiesce();
		if (fail_count == 0)
			$display("saved_index_table_search_2d: match");
		else
			$display("saved_index_table_search_2d: mismatch");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/sits_pkg.sv
rtl/sits_ram.sv
rtl/sits_lane.sv
rtl/sits_merge.sv
rtl/saved_index_table_search_2d.sv
rtl/sits_checker.sv
verif/tb.sv
